@@ src/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/htdar_pkg.sv @@
`timescale 1ns / 1ps
package htdar_pkg;
   localparam int TABLE_ENTRIES_DEFAULT = 4001;
   localparam int AGE_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_PROBE = 2'd1,
      OP_AGE   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [7:0]  depth;
      logic [31:0] score;
      logic [1:0]  node_kind;
      logic [31:0] move_code;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  found_depth;
      logic [31:0] found_score;
      logic [1:0]  found_kind;
      logic [31:0] found_move;
   } rsp_type;
endpackage

@@ src/htdar_if.sv @@
`timescale 1ns / 1ps
interface htdar_if #(type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/htdar_front.sv @@
`timescale 1ns / 1ps
// Front: computes the slot index (key mod TABLE_ENTRIES) one 8-bit digit per
// cycle, then pushes the item into a two-entry queue.
module htdar_front #(
   parameter int TABLE_ENTRIES = htdar_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_BITS = $clog2(TABLE_ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  htdar_pkg::req_type   in_data,
   output logic                 q_valid,
   input  logic                 q_ready,
   output htdar_pkg::req_type   q_data,
   output logic [IDX_BITS-1:0]  q_idx
);
   localparam int RB = IDX_BITS + 9;
   localparam logic [9:0] RECIP = 10'((64'd1 << RB) / 64'(TABLE_ENTRIES));

   typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_PUSH} state_type;

   state_type            state_ff;
   htdar_pkg::req_type   item_ff;
   logic [IDX_BITS-1:0]  rem_ff;
   logic [2:0]           digit_ff;
   logic [RB-1:0]        wide;
   logic [RB-1:0]        red;
   logic [IDX_BITS-1:0]  rem_in;

   htdar_pkg::req_type   fifo_data_ff [2];
   logic [IDX_BITS-1:0]  fifo_idx_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push, pop;

   // Horner step: rem*256 + next byte, then reduce below TABLE_ENTRIES.
   // The partial value is below 256*N, so a reciprocal multiply gives a
   // quotient estimate that is at most one low, and one correction follows.
   always_comb begin
      logic [9:0]    q8;
      logic [RB+9:0] prod;
      logic [RB+9:0] qn;
      wide = {1'b0, rem_ff, 8'h00}
           | RB'(item_ff.key[8*digit_ff +: 8]);
      prod = (RB+10)'(wide) * (RB+10)'(RECIP);
      q8 = prod[RB+9:RB];
      qn = (RB+10)'(q8) * (RB+10)'(TABLE_ENTRIES);
      red = wide - qn[RB-1:0];
      if (red >= RB'(TABLE_ENTRIES)) begin
         red = red - RB'(TABLE_ENTRIES);
      end
      rem_in = red[IDX_BITS-1:0];
   end

   assign push = (state_ff == S_PUSH) && (count_ff != 2'd2);
   assign pop = q_valid && q_ready;
   assign in_ready = (state_ff == S_IDLE);
   assign q_valid = (count_ff != 2'd0);
   assign q_data = fifo_data_ff[rd_ptr_ff];
   assign q_idx = fifo_idx_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  item_ff <= in_data;
                  rem_ff <= '0;
                  digit_ff <= 3'd7;
                  state_ff <= S_REDUCE;
               end
            end
            S_REDUCE: begin
               rem_ff <= rem_in;
               digit_ff <= digit_ff - 3'd1;
               if (digit_ff == 3'd0) begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (push) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (push) begin
            fifo_data_ff[wr_ptr_ff] <= item_ff;
            fifo_idx_ff[wr_ptr_ff] <= rem_ff;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

@@ src/htdar_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Back: executes table operations against the entry memory with an epoch
// mark per entry, so a clear only advances the epoch unless the epoch wraps.
module htdar_back #(
   parameter int TABLE_ENTRIES = htdar_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AGE_BITS = htdar_pkg::AGE_BITS_DEFAULT,
   parameter int IDX_BITS = $clog2(TABLE_ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  htdar_pkg::req_type   q_data,
   input  logic [IDX_BITS-1:0]  q_idx,
   output logic                 out_valid,
   input  logic                 out_ready,
   output htdar_pkg::rsp_type   out_data
);
   localparam int EB = 16;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_OUT} state_type;

   typedef struct packed {
      logic [63:0]         key;
      logic [7:0]          depth;
      logic [31:0]         score;
      logic [1:0]          kind;
      logic [31:0]         move;
      logic [AGE_BITS-1:0] age;
      logic [EB-1:0]       epoch;
   } entry_type;

   entry_type            mem [TABLE_ENTRIES];
   entry_type            rd_ff;
   entry_type            cur;
   entry_type            wr;
   state_type            state_ff;
   htdar_pkg::req_type   item_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [AGE_BITS-1:0]  age_ff;
   logic [EB-1:0]        epoch_ff;
   logic                 wipe_ff;
   logic [IDX_BITS-1:0]  wipe_idx_ff;
   htdar_pkg::rsp_type   rsp_ff;
   htdar_pkg::rsp_type   rsp_in;
   logic                 do_write;
   logic                 hit;

   // A stale epoch means the entry reads as zero. Epoch wrap would alias,
   // so on wrap a full sweep clears the memory.
   always_comb begin
      cur = (rd_ff.epoch == epoch_ff) ? rd_ff : '0;
      wr.key = item_ff.key;
      wr.depth = item_ff.depth;
      wr.score = item_ff.score;
      wr.kind = item_ff.node_kind;
      wr.move = item_ff.move_code;
      wr.age = age_ff;
      wr.epoch = epoch_ff;
      do_write = (state_ff == S_EXEC) && (item_ff.op == htdar_pkg::OP_STORE)
         && ((cur.age < age_ff) || (cur.depth <= item_ff.depth));
      hit = (cur.key == item_ff.key) && (cur.depth >= item_ff.depth);
      rsp_in = '0;
      if ((item_ff.op == htdar_pkg::OP_PROBE) && hit) begin
         rsp_in.hit = 1'b1;
         rsp_in.found_depth = cur.depth;
         rsp_in.found_score = cur.score;
         rsp_in.found_kind = cur.kind;
         rsp_in.found_move = cur.move;
      end
   end

   assign q_ready = (state_ff == S_IDLE) && !wipe_ff;
   assign out_valid = (state_ff == S_OUT);
   assign out_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_ff <= mem[idx_ff];
      end
      if (wipe_ff) begin
         mem[wipe_idx_ff] <= '0;
      end else if (do_write) begin
         mem[idx_ff] <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         age_ff <= '0;
         epoch_ff <= EB'(1);
         wipe_ff <= 1'b1;
         wipe_idx_ff <= '0;
      end else begin
         if (wipe_ff) begin
            wipe_idx_ff <= wipe_idx_ff + 1'b1;
            if (wipe_idx_ff == IDX_BITS'(TABLE_ENTRIES - 1)) begin
               wipe_ff <= 1'b0;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  item_ff <= q_data;
                  idx_ff <= q_idx;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               rsp_ff <= rsp_in;
               case (item_ff.op)
                  htdar_pkg::OP_AGE: begin
                     if (age_ff != '1) begin
                        age_ff <= age_ff + 1'b1;
                     end
                  end
                  htdar_pkg::OP_CLEAR: begin
                     age_ff <= '0;
                     if (epoch_ff == '1) begin
                        epoch_ff <= EB'(1);
                        wipe_ff <= 1'b1;
                        wipe_idx_ff <= '0;
                     end else begin
                        epoch_ff <= epoch_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_no_write_wipe, clock, reset, wipe_ff, !do_write)
   `ASSERT_IMPLY(a_rsp_zero_miss, clock, reset, out_valid && !rsp_ff.hit, rsp_ff == '0)
   `ASSERT_NEXT(a_exec_to_out, clock, reset, state_ff == S_EXEC, state_ff == S_OUT)
endmodule

@@ src/hash_table_depth_age_replace.sv @@
`timescale 1ns / 1ps
// Direct-mapped transposition table with depth-preferred, age-aware
// replacement. Each word on req yields exactly one word on rsp. The front
// takes a word, reduces the key modulo TABLE_ENTRIES one byte per cycle and
// then enqueues it, stalling while its queue is full, and takes no new word
// until the last one is enqueued. The back steps through take, memory read,
// execute and output states and takes no new word until its result word is
// taken. Clear advances an epoch mark instead of touching the memory; after
// reset, and on every 65535th clear, the back sweeps all TABLE_ENTRIES
// entries, one per cycle, before it takes a word.
module hash_table_depth_age_replace #(
   parameter int TABLE_ENTRIES = htdar_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AGE_BITS = htdar_pkg::AGE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_key,
   input  logic [7:0]  req_depth,
   input  logic [31:0] req_score,
   input  logic [1:0]  req_node_kind,
   input  logic [31:0] req_move_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [7:0]  rsp_found_depth,
   output logic [31:0] rsp_found_score,
   output logic [1:0]  rsp_found_kind,
   output logic [31:0] rsp_found_move
);
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);

   htdar_if #(.payload_type(htdar_pkg::req_type)) req_ch ();
   htdar_if #(.payload_type(htdar_pkg::rsp_type)) rsp_ch ();
   htdar_pkg::req_type  q_data;
   logic                q_valid, q_ready;
   logic [IDX_BITS-1:0] q_idx;

   assign req_ch.valid = req_valid;
   assign req_ch.data = '{op: req_op, key: req_key, depth: req_depth, score: req_score,
      node_kind: req_node_kind, move_code: req_move_code};
   assign req_ready = req_ch.ready;

   htdar_front #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_BITS(IDX_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_data(req_ch.data),
      .q_valid, .q_ready, .q_data, .q_idx
   );

   htdar_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .AGE_BITS(AGE_BITS), .IDX_BITS(IDX_BITS))
   u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_data, .q_idx,
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp_ch.data)
   );

   assign rsp_ch.ready = rsp_ready;
   assign rsp_valid = rsp_ch.valid;
   assign rsp_hit = rsp_ch.data.hit;
   assign rsp_found_depth = rsp_ch.data.found_depth;
   assign rsp_found_score = rsp_ch.data.found_score;
   assign rsp_found_kind = rsp_ch.data.found_kind;
   assign rsp_found_move = rsp_ch.data.found_move;
endmodule

@@ verif/htdar_tb_if.sv @@
`timescale 1ns / 1ps
interface htdar_chan_if #(type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ verif/hash_table_depth_age_replace_tb.sv @@
`timescale 1ns / 1ps
module hash_table_depth_age_replace_tb;
   localparam int ENTRIES = htdar_pkg::TABLE_ENTRIES_DEFAULT;
   localparam logic [15:0] AGE_TOP = 16'hFFFF;

   class probe_board;
      logic [63:0] tag_mem [ENTRIES];
      logic [7:0]  depth_mem [ENTRIES];
      logic [31:0] score_mem [ENTRIES];
      logic [1:0]  kind_mem [ENTRIES];
      logic [31:0] move_mem [ENTRIES];
      logic [15:0] age_mem [ENTRIES];
      logic [15:0] cur_age;
      htdar_pkg::rsp_type pending [$];
      int          errors;

      function void wipe();
         for (int i = 0; i < ENTRIES; i++) begin
            tag_mem[i] = '0;
            depth_mem[i] = '0;
            score_mem[i] = '0;
            kind_mem[i] = '0;
            move_mem[i] = '0;
            age_mem[i] = '0;
         end
         cur_age = '0;
      endfunction

      function void note_request(htdar_pkg::req_type r);
         int                 slot;
         htdar_pkg::rsp_type o;
         slot = int'(r.key % 64'(ENTRIES));
         o = '0;
         case (htdar_pkg::op_type'(r.op))
            htdar_pkg::OP_STORE: begin
               if (age_mem[slot] < cur_age || depth_mem[slot] <= r.depth) begin
                  tag_mem[slot] = r.key;
                  depth_mem[slot] = r.depth;
                  score_mem[slot] = r.score;
                  kind_mem[slot] = r.node_kind;
                  move_mem[slot] = r.move_code;
                  age_mem[slot] = cur_age;
               end
            end
            htdar_pkg::OP_PROBE: begin
               if (tag_mem[slot] == r.key && depth_mem[slot] >= r.depth) begin
                  o.hit = 1'b1;
                  o.found_depth = depth_mem[slot];
                  o.found_score = score_mem[slot];
                  o.found_kind = kind_mem[slot];
                  o.found_move = move_mem[slot];
               end
            end
            htdar_pkg::OP_AGE: begin
               if (cur_age != AGE_TOP) cur_age = cur_age + 16'd1;
            end
            default: wipe();
         endcase
         pending.push_back(o);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(htdar_pkg::rsp_type got);
         htdar_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report("response with none expected");
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("hit %0d want %0d", got.hit, want.hit));
         if (got.found_depth !== want.found_depth)
            report($sformatf("depth %0h want %0h", got.found_depth, want.found_depth));
         if (got.found_score !== want.found_score)
            report($sformatf("score %0h want %0h", got.found_score, want.found_score));
         if (got.found_kind !== want.found_kind)
            report($sformatf("kind %0h want %0h", got.found_kind, want.found_kind));
         if (got.found_move !== want.found_move)
            report($sformatf("move %0h want %0h", got.found_move, want.found_move));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   hold_cycles = 0;
   bit   hold_on = 1'b0;
   probe_board board;
   logic [63:0] key_pool [8];

   htdar_chan_if #(htdar_pkg::req_type) req_ch (clock);
   htdar_chan_if #(htdar_pkg::rsp_type) rsp_ch (clock);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hash_table_depth_age_replace dut (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_op(req_ch.data.op), .req_key(req_ch.data.key),
      .req_depth(req_ch.data.depth), .req_score(req_ch.data.score),
      .req_node_kind(req_ch.data.node_kind), .req_move_code(req_ch.data.move_code),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_hit(rsp_ch.data.hit), .rsp_found_depth(rsp_ch.data.found_depth),
      .rsp_found_score(rsp_ch.data.found_score), .rsp_found_kind(rsp_ch.data.found_kind),
      .rsp_found_move(rsp_ch.data.found_move)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      board = new();
      board.wipe();
      board.errors = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
   end

   // The receiver stalls on its own pattern, with one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_on) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 400) hold_on <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send(htdar_pkg::req_type r);
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_gap();
      int n;
      n = $urandom_range(0, 3);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic htdar_pkg::req_type make_req(htdar_pkg::op_type op, logic [63:0] key,
                                                   logic [7:0] depth);
      htdar_pkg::req_type r;
      r.op = op;
      r.key = key;
      r.depth = depth;
      r.score = $urandom();
      r.node_kind = 2'($urandom_range(0, 3));
      r.move_code = $urandom();
      return r;
   endfunction

   function automatic htdar_pkg::req_type random_req();
      logic [63:0]      key;
      int               pick;
      htdar_pkg::op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 45) op = htdar_pkg::OP_STORE;
      else if (pick < 90) op = htdar_pkg::OP_PROBE;
      else if (pick < 99) op = htdar_pkg::OP_AGE;
      else op = htdar_pkg::OP_CLEAR;
      if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, 7)];
      else key = {$urandom(), $urandom()};
      if ($urandom_range(0, 5) == 0) key = key + 64'(ENTRIES) * $urandom_range(1, 3);
      return make_req(op, key, 8'($urandom_range(0, 255)));
   endfunction

   initial begin
      htdar_pkg::req_type r;
      int                 burst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom(), $urandom()};
      @(posedge clock);
      send(make_req(htdar_pkg::OP_PROBE, 64'd0, 8'd0));
      send(make_req(htdar_pkg::OP_PROBE, 64'd0, 8'd1));
      send(make_req(htdar_pkg::OP_STORE, '1, 8'd255));
      send(make_req(htdar_pkg::OP_PROBE, '1, 8'd255));
      send(make_req(htdar_pkg::OP_STORE, '1 - 64'(ENTRIES), 8'd10));
      send(make_req(htdar_pkg::OP_PROBE, '1 - 64'(ENTRIES), 8'd0));
      send(make_req(htdar_pkg::OP_STORE, 64'd5, 8'd0));
      r = make_req(htdar_pkg::OP_STORE, 64'd5, 8'd0);
      r.score = '1; r.move_code = '1; r.node_kind = 2'd3;
      send(r);
      send(make_req(htdar_pkg::OP_PROBE, 64'd5, 8'd0));
      send(make_req(htdar_pkg::OP_STORE, 64'd5 + 64'(ENTRIES), 8'd0));
      send(make_req(htdar_pkg::OP_PROBE, 64'd5, 8'd0));
      send(make_req(htdar_pkg::OP_STORE, 64'd77, 8'd50));
      send(make_req(htdar_pkg::OP_STORE, 64'd77, 8'd20));
      send(make_req(htdar_pkg::OP_PROBE, 64'd77, 8'd50));
      send(make_req(htdar_pkg::OP_AGE, '0, '0));
      send(make_req(htdar_pkg::OP_STORE, 64'd77, 8'd20));
      send(make_req(htdar_pkg::OP_PROBE, 64'd77, 8'd21));
      send(make_req(htdar_pkg::OP_PROBE, 64'd77, 8'd20));
      send(make_req(htdar_pkg::OP_CLEAR, '0, '0));
      send(make_req(htdar_pkg::OP_PROBE, 64'd77, 8'd0));
      send(make_req(htdar_pkg::OP_PROBE, 64'd0, 8'd0));
      send(make_req(htdar_pkg::OP_STORE, 64'd9, 8'd100));
      send(make_req(htdar_pkg::OP_STORE, 64'd9, 8'd3));
      send(make_req(htdar_pkg::OP_PROBE, 64'd9, 8'd0));
      send(make_req(htdar_pkg::OP_CLEAR, '0, '0));
      hold_cycles <= 0;
      hold_on <= 1'b1;
      for (int n = 0; n < 450; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            send(random_req());
            n++;
         end
         send_gap();
      end
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
